// ===== src/gftj_pkg.sv =====
`default_nettype none
package gftj_pkg;

  localparam int MaxWidth = 64;
  localparam int MaxWords = 32;
  localparam int PosW = 7;
  localparam int IdxW = 6;
  localparam int WrdW = 5;
  localparam int CntW = 6;
  localparam logic [7:0] SpaceChar = 8'd32;
  localparam logic [PosW-1:0] WidthReset = 7'd16;
  localparam logic [1:0] RegLineWidth = 2'd0;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_COPY,
    ST_DIV,
    ST_EMIT,
    ST_LAST
  } state_t;

endpackage
`default_nettype wire

// ===== src/greedy_full_text_justifier.sv =====
`default_nettype none
// Greedy full-text justifier.
// Input stream: one character per request; tdata is ch, tuser carries flush in
// bit 0 and word_end in bit 1. A flush request ends the text and sends the held
// line left-justified; its character is ignored.
// Output stream: one line character per request; tdata is out_ch, tlast is
// line_end and tuser is word_cut. line_width sits at APB address 0; the user must
// write it only while the block is idle, and the block itself does not enforce this.
// The block takes no request while it works on one. A character inside a word
// is stored in the word store, up to the line width. A closing character whose
// word fits the held line is copied into it from the word store. A word that
// does not fit first has the held line sent: the restoring divider works out the
// gap spacing, the line walker sends the line, and then the new word is copied
// into the emptied line. A flush with held words starts its line without the
// divider. A stalled receiver holds the output register and the line walker in
// place.
// Reset clears the line and word state and sets line_width to 16; the
// character stores need no clearing.
module greedy_full_text_justifier (
  input  wire        clk,
  input  wire        rst,
  input  wire        s_tvalid,
  output logic       s_tready,
  input  wire  [7:0] s_tdata,   // [7:0] ch
  input  wire  [1:0] s_tuser,   // [0] flush, [1] word_end
  output logic       m_tvalid,
  input  wire        m_tready,
  output logic [7:0] m_tdata,   // [7:0] out_ch
  output logic       m_tlast,   // line_end
  output logic       m_tuser,   // [0] word_cut
  input  wire        psel,
  input  wire        penable,
  input  wire        pwrite,
  input  wire  [1:0] paddr,
  input  wire  [31:0] pwdata,
  output logic [31:0] prdata,
  output logic       pready
);

  gftj_pkg::state_t state, state_next;

  logic [6:0] line_width;
  logic [7:0] line_chars [gftj_pkg::MaxWidth];
  logic [6:0] line_word_lengths [gftj_pkg::MaxWords];
  logic [6:0] line_letter_total;
  logic [5:0] line_word_count;
  logic [7:0] word_chars [gftj_pkg::MaxWidth];
  logic [6:0] word_length;
  logic       word_over;
  logic       cut_flag;

  logic [6:0] w;
  logic       flush_in, wend_in;
  logic       acc;
  logic [6:0] wl_after;
  logic [6:0] len_eff;
  logic [7:0] need;
  logic       fits;
  logic       word_over_n;
  logic       line_wide;

  // Emission context, captured when a line is to go out.
  logic        just;
  logic [5:0]  e_n;
  logic        e_cut;
  logic        e_wide;
  logic [6:0]  q, r;
  logic        add_after;
  logic [6:0]  pend_len;

  // Divider state.
  logic [6:0]  dv_num, dv_rem;
  logic [2:0]  dv_cnt;
  logic [6:0]  gaps;
  logic [7:0]  dv_trial;

  // Copy and line walker state.
  logic [6:0]  cp_k;
  logic        cp_wr;
  logic [7:0]  cp_dst;
  logic [6:0]  pos;
  logic [6:0]  src, src_next;
  logic [4:0]  wi;
  logic [6:0]  wk;
  logic [6:0]  sp;
  logic        in_gap;
  logic        tail;
  logic        slot_char;
  logic [6:0]  wlen_cur;
  logic [6:0]  gap_sz;
  logic        emit_go;
  logic        emit_done;
  logic [7:0]  word_rd;
  logic [7:0]  line_rd;

  // Configuration port.
  assign pready = 1'b1;
  always_comb begin
    prdata = 32'd0;
    if (paddr == gftj_pkg::RegLineWidth) prdata = {25'd0, line_width};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_width <= gftj_pkg::WidthReset;
    end else if (psel && penable && pwrite && pready &&
                 paddr == gftj_pkg::RegLineWidth) begin
      line_width <= pwdata[6:0];
    end
  end

  // Effective width 1..64.
  always_comb begin
    w = line_width;
    if (w == 7'd0) w = 7'd1;
    if (w > 7'(gftj_pkg::MaxWidth)) w = 7'(gftj_pkg::MaxWidth);
  end

  assign flush_in = s_tuser[0];
  assign wend_in  = s_tuser[1];
  assign acc      = s_tvalid && s_tready;

  // Word length after this character, the fit test and the overfull test.
  always_comb begin
    wl_after = (word_length < w) ? word_length + 7'd1 : word_length;
    word_over_n = word_over || (word_length >= w);
    len_eff = (wl_after > w) ? w : wl_after;
    need = {1'b0, line_letter_total} + {2'b0, line_word_count} + {1'b0, len_eff};
    fits = (line_word_count == 6'd0) ||
           (line_word_count < 6'(gftj_pkg::MaxWords) && need <= {1'b0, w});
    line_wide = ({1'b0, line_letter_total} + {2'b0, line_word_count} - 8'd1) > {1'b0, w};
  end

  assign gaps     = {1'b0, e_n} - 7'd1;
  assign dv_trial = {dv_rem, dv_num[6]} - {1'b0, gaps};

  // Current slot of the line walker.
  assign slot_char = !tail && !in_gap;
  assign wlen_cur  = line_word_lengths[wi];
  assign gap_sz    = q + (({2'b0, wi} < r) ? 7'd1 : 7'd0);
  assign cp_dst    = {1'b0, line_letter_total} + {1'b0, cp_k} - 8'd1;

  // State outputs.
  always_comb begin
    s_tready  = (state == gftj_pkg::ST_IDLE);
    emit_go   = (state == gftj_pkg::ST_EMIT) && (pos != w) && (!m_tvalid || m_tready);
    emit_done = (state == gftj_pkg::ST_EMIT) && (pos == w) && (!m_tvalid || m_tready);
    cp_wr     = (state == gftj_pkg::ST_COPY) && (cp_k != 7'd0);
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      gftj_pkg::ST_IDLE: begin
        if (acc) begin
          if (flush_in) begin
            if (line_word_count != 6'd0) state_next = gftj_pkg::ST_EMIT;
          end else if (wend_in) begin
            state_next = fits ? gftj_pkg::ST_COPY : gftj_pkg::ST_DIV;
          end
        end
      end
      gftj_pkg::ST_DIV: begin
        if (dv_cnt == 3'd6) state_next = gftj_pkg::ST_EMIT;
      end
      gftj_pkg::ST_EMIT: begin
        if (emit_done) state_next = add_after ? gftj_pkg::ST_COPY : gftj_pkg::ST_IDLE;
      end
      gftj_pkg::ST_COPY: begin
        if (cp_k == pend_len) state_next = gftj_pkg::ST_IDLE;
      end
      default: state_next = gftj_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= gftj_pkg::ST_IDLE;
    else state <= state_next;
  end

  // Word store: written as characters arrive, read through a register in the cycle before the copy writes it.
  always_ff @(posedge clk) begin
    if (acc && !flush_in && word_length < w) word_chars[word_length[5:0]] <= s_tdata;
    word_rd <= word_chars[cp_k[5:0]];
  end

  // Line store: the copy writes the word read in the previous cycle.
  always_ff @(posedge clk) begin
    if (cp_wr && cp_dst < 8'(gftj_pkg::MaxWidth)) line_chars[cp_dst[5:0]] <= word_rd;
  end

  // The line read address runs at the next source position, so the read data
  // always matches the current one. Every line starts at the first character.
  always_comb begin
    src_next = src;
    if (state == gftj_pkg::ST_IDLE) src_next = 7'd0;
    else if (emit_go && slot_char) src_next = src + 7'd1;
  end

  always_ff @(posedge clk) begin
    src     <= src_next;
    line_rd <= line_chars[src_next[5:0]];
  end

  // Word lengths of the held line.
  always_ff @(posedge clk) begin
    if (acc && !flush_in && wend_in && fits)
      line_word_lengths[line_word_count[4:0]] <= len_eff;
    else if (emit_done && add_after)
      line_word_lengths[5'd0] <= pend_len;
  end

  // Output register and main control.
  always_ff @(posedge clk) begin
    if (rst) begin
      line_letter_total <= 7'd0;
      line_word_count   <= 6'd0;
      word_length       <= 7'd0;
      word_over         <= 1'b0;
      cut_flag          <= 1'b0;
      m_tvalid          <= 1'b0;
      add_after         <= 1'b0;
      cp_k              <= 7'd0;
      pos               <= 7'd0;
      dv_cnt            <= 3'd0;
    end else begin
      // Load the next line slot, or drop a character the receiver took.
      if (emit_go) begin
        m_tvalid <= 1'b1;
        m_tlast  <= (pos == w - 7'd1);
        m_tuser  <= e_cut;
        pos      <= pos + 7'd1;
        if (slot_char) begin
          m_tdata <= line_rd;
          if (wk + 7'd1 == wlen_cur) begin
            wk <= 7'd0;
            if ({1'b0, wi} + 6'd1 < e_n) begin
              in_gap <= 1'b1;
              sp     <= 7'd0;
            end else begin
              tail <= 1'b1;
            end
          end else begin
            wk <= wk + 7'd1;
          end
        end else begin
          m_tdata <= gftj_pkg::SpaceChar;
          if (in_gap) begin
            if (sp + 7'd1 == gap_sz) begin
              in_gap <= 1'b0;
              wi     <= wi + 5'd1;
            end else begin
              sp <= sp + 7'd1;
            end
          end
        end
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end

      case (state)
        gftj_pkg::ST_IDLE: begin
          if (acc) begin
            if (flush_in) begin
              // The held line goes out as it is; the open word is dropped.
              just <= 1'b0; e_n <= line_word_count;
              e_wide <= line_wide; e_cut <= cut_flag || line_wide;
              q <= 7'd1; r <= 7'd0;
              add_after <= 1'b0;
              pos <= 7'd0; wi <= 5'd0; wk <= 7'd0; sp <= 7'd0;
              in_gap <= 1'b0; tail <= 1'b0;
              line_letter_total <= 7'd0; line_word_count <= 6'd0; cut_flag <= 1'b0;
              word_length <= 7'd0; word_over <= 1'b0;
            end else begin
              if (word_length < w) word_length <= word_length + 7'd1;
              word_over <= word_over_n;
              if (wend_in) begin
                pend_len <= len_eff;
                word_length <= 7'd0; word_over <= 1'b0;
                cp_k <= 7'd0;
                if (fits) begin
                  add_after <= 1'b0;
                  cut_flag <= cut_flag | word_over_n;
                  line_word_count <= line_word_count + 6'd1;
                end else begin
                  // Send the held line justified; the new word starts the next one.
                  just <= 1'b1; e_n <= line_word_count;
                  e_wide <= line_wide; e_cut <= cut_flag || line_wide;
                  q <= 7'd1; r <= 7'd0;
                  dv_num <= w - line_letter_total; dv_rem <= 7'd0; dv_cnt <= 3'd0;
                  add_after <= 1'b1;
                  pos <= 7'd0; wi <= 5'd0; wk <= 7'd0; sp <= 7'd0;
                  in_gap <= 1'b0; tail <= 1'b0;
                  line_letter_total <= 7'd0; line_word_count <= 6'd1;
                  cut_flag <= word_over_n;
                end
              end
            end
          end
        end
        gftj_pkg::ST_DIV: begin
          // One quotient bit per cycle through the subtractor.
          if (dv_trial[7]) begin
            dv_rem <= {dv_rem[5:0], dv_num[6]};
            dv_num <= {dv_num[5:0], 1'b0};
          end else begin
            dv_rem <= dv_trial[6:0];
            dv_num <= {dv_num[5:0], 1'b1};
          end
          dv_cnt <= dv_cnt + 3'd1;
          if (dv_cnt == 3'd6 && just && e_n > 6'd1 && !e_wide) begin
            q <= dv_trial[7] ? {dv_num[5:0], 1'b0} : {dv_num[5:0], 1'b1};
            r <= dv_trial[7] ? {dv_rem[5:0], dv_num[6]} : dv_trial[6:0];
          end
        end
        gftj_pkg::ST_COPY: begin
          cp_k <= cp_k + 7'd1;
          if (cp_k == pend_len) line_letter_total <= line_letter_total + pend_len;
        end
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire
